>>> src/ppt_pkg.sv
package ppt_pkg;

	localparam int WORD_W = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int EPS_W = 31;

	typedef struct packed {
		logic signed [WORD_W-1:0] x_in;
		logic signed [WORD_W-1:0] y_in;
	} ppt_in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] x_out;
		logic signed [WORD_W-1:0] y_out;
		logic                     w_small;
	} ppt_out_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_M0_M1 = 3'd0,
		REG_M2_M3 = 3'd1,
		REG_M4_M5 = 3'd2,
		REG_M6_M7 = 3'd3,
		REG_M8    = 3'd4,
		REG_EPS   = 3'd5
	} ppt_reg_t;

	localparam logic [WORD_W-1:0] COEF_ONE  = 32'h0001_0000;
	localparam logic [WORD_W-1:0] COEF_ZERO = 32'h0000_0000;
	localparam logic [EPS_W-1:0]  EPS_RESET = 31'd1;

endpackage

>>> src/projective_point_transform_2d.sv
// channel | dir | handshake               | payload
// in      | in  | in_valid / in_ready     | in_data (x_in, y_in)
// out     | out | out_valid / out_ready   | out_data (x_out, y_out, w_small)
// cfg     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one word per cycle while out is not stalled; data passes two multiply/sum stages,
// a sign stage, the bit-per-stage divider and an output register.
// async reset clears valid bits and loads the identity matrix.
// a stall on out freezes the whole pipeline; in_ready follows it.
// cfg_ready is always high.
module projective_point_transform_2d import ppt_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ppt_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ppt_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int VAL_W = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
	localparam int SUM_W = 2 * VAL_W + 2;
	localparam int DIV_LAT = VAL_W + 2;
	localparam int NST = 4 + DIV_LAT;

	logic [WORD_W-1:0] m_q [0:8];
	logic [EPS_W-1:0]  eps_q;
	logic              en;
	logic              vld_s [0:NST-1];

	logic signed [VAL_W-1:0] x, y;
	logic signed [VAL_W-1:0] m [0:8];
	logic signed [SUM_W-1:0] xp_s2, yp_s2, w_s2;

	logic [SUM_W-1:0]  xm_s3, ym_s3, wm_s3;
	logic              small_s3, negx_s3, negy_s3;
	logic [VAL_W-1:0]  satx_s3, saty_s3;

	logic              small_d [0:DIV_LAT];
	logic              negx_d  [0:DIV_LAT];
	logic              negy_d  [0:DIV_LAT];
	logic [VAL_W-1:0]  satx_d  [0:DIV_LAT];
	logic [VAL_W-1:0]  saty_d  [0:DIV_LAT];

	logic [VAL_W:0]    qx, qy;
	logic              ovx, ovy;
	logic [VAL_W-1:0]  rx, ry;

	function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
		return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
	endfunction

	function automatic logic [VAL_W-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi, lo;
		hi = SUM_W'((SUM_W'(1) << (VAL_W - 1)) - SUM_W'(1));
		lo = -hi - SUM_W'(1);
		if (v > hi) return hi[VAL_W-1:0];
		if (v < lo) return lo[VAL_W-1:0];
		return v[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] fin(input logic [VAL_W:0] q, input logic ov,
		input logic neg);
		logic [VAL_W:0] lim, qs;
		lim = ((VAL_W+1)'(1) << (VAL_W - 1)) - (neg ? (VAL_W+1)'(0) : (VAL_W+1)'(1));
		qs = (ov || q > lim) ? lim : q;
		return neg ? VAL_W'(-qs) : VAL_W'(qs);
	endfunction

	// config registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q[0] <= COEF_ONE;  m_q[1] <= COEF_ZERO;
			m_q[2] <= COEF_ZERO; m_q[3] <= COEF_ZERO;
			m_q[4] <= COEF_ONE;  m_q[5] <= COEF_ZERO;
			m_q[6] <= COEF_ZERO; m_q[7] <= COEF_ZERO;
			m_q[8] <= COEF_ONE;
			eps_q  <= EPS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_M0_M1: begin m_q[0] <= cfg_data[63:32]; m_q[1] <= cfg_data[31:0]; end
				REG_M2_M3: begin m_q[2] <= cfg_data[63:32]; m_q[3] <= cfg_data[31:0]; end
				REG_M4_M5: begin m_q[4] <= cfg_data[63:32]; m_q[5] <= cfg_data[31:0]; end
				REG_M6_M7: begin m_q[6] <= cfg_data[63:32]; m_q[7] <= cfg_data[31:0]; end
				REG_M8:    m_q[8] <= cfg_data[31:0];
				REG_EPS:   eps_q <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < 9; i++) begin : g_coef
		assign m[i] = m_q[i][VAL_W-1:0];
	end

	assign x = in_data.x_in[VAL_W-1:0];
	assign y = in_data.y_in[VAL_W-1:0];

	// whole pipeline moves unless the output word is held
	assign en = !vld_s[NST-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < NST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	ppt_dot3 #(.VAL_W(VAL_W), .FRAC_W(FRAC_BITS), .SUM_W(SUM_W)) u_dx (
		.clk(clk), .en(en), .x(x), .y(y), .a(m[0]), .b(m[1]), .c(m[2]), .r_s2(xp_s2));
	ppt_dot3 #(.VAL_W(VAL_W), .FRAC_W(FRAC_BITS), .SUM_W(SUM_W)) u_dy (
		.clk(clk), .en(en), .x(x), .y(y), .a(m[3]), .b(m[4]), .c(m[5]), .r_s2(yp_s2));
	ppt_dot3 #(.VAL_W(VAL_W), .FRAC_W(FRAC_BITS), .SUM_W(SUM_W)) u_dw (
		.clk(clk), .en(en), .x(x), .y(y), .a(m[6]), .b(m[7]), .c(m[8]), .r_s2(w_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			xm_s3    <= mag(xp_s2);
			ym_s3    <= mag(yp_s2);
			wm_s3    <= mag(w_s2);
			small_s3 <= !(mag(w_s2) > SUM_W'(eps_q));
			negx_s3  <= xp_s2[SUM_W-1] != w_s2[SUM_W-1];
			negy_s3  <= yp_s2[SUM_W-1] != w_s2[SUM_W-1];
			satx_s3  <= sat(xp_s2);
			saty_s3  <= sat(yp_s2);
		end
	end

	ppt_div #(.VAL_W(VAL_W), .FRAC_W(FRAC_BITS), .SUM_W(SUM_W)) u_divx (
		.clk(clk), .en(en), .num(xm_s3), .den(wm_s3), .quo(qx), .ovf(ovx));
	ppt_div #(.VAL_W(VAL_W), .FRAC_W(FRAC_BITS), .SUM_W(SUM_W)) u_divy (
		.clk(clk), .en(en), .num(ym_s3), .den(wm_s3), .quo(qy), .ovf(ovy));

	// side data riding along with the divider
	assign small_d[0] = small_s3;
	assign negx_d[0]  = negx_s3;
	assign negy_d[0]  = negy_s3;
	assign satx_d[0]  = satx_s3;
	assign saty_d[0]  = saty_s3;
	for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				small_d[k+1] <= small_d[k];
				negx_d[k+1]  <= negx_d[k];
				negy_d[k+1]  <= negy_d[k];
				satx_d[k+1]  <= satx_d[k];
				saty_d[k+1]  <= saty_d[k];
			end
		end
	end

	assign rx = small_d[DIV_LAT - 1 + 1] ? satx_d[DIV_LAT] : fin(qx, ovx, negx_d[DIV_LAT]);
	assign ry = small_d[DIV_LAT] ? saty_d[DIV_LAT] : fin(qy, ovy, negy_d[DIV_LAT]);

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.x_out   <= WORD_W'(signed'(rx));
			out_data.y_out   <= WORD_W'(signed'(ry));
			out_data.w_small <= small_d[DIV_LAT];
		end
	end
endmodule

>>> src/ppt_dot3.sv
module ppt_dot3 import ppt_pkg::*; #(
	parameter int VAL_W  = 32,
	parameter int FRAC_W = 16,
	parameter int SUM_W  = 66
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [VAL_W-1:0] x,
	input  logic signed [VAL_W-1:0] y,
	input  logic signed [VAL_W-1:0] a,
	input  logic signed [VAL_W-1:0] b,
	input  logic signed [VAL_W-1:0] c,
	output logic signed [SUM_W-1:0] r_s2
);
	logic signed [2*VAL_W-1:0] p0_s1, p1_s1;
	logic signed [VAL_W-1:0]   c_s1;
	logic signed [SUM_W-1:0]   sum;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= a * x;
			p1_s1 <= b * y;
			c_s1  <= c;
		end
	end

	// exact sum, floored once to the fraction width
	assign sum = SUM_W'(p0_s1) + SUM_W'(p1_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2 <= (sum >>> FRAC_W) + SUM_W'(c_s1);
		end
	end
endmodule

>>> src/ppt_div.sv
module ppt_div import ppt_pkg::*; #(
	parameter int VAL_W  = 32,
	parameter int FRAC_W = 16,
	parameter int SUM_W  = 66
) (
	input  logic               clk,
	input  logic               en,
	input  logic [SUM_W-1:0]   num,
	input  logic [SUM_W-1:0]   den,
	output logic [VAL_W:0]     quo,
	output logic               ovf
);
	localparam int NW = SUM_W + FRAC_W;
	localparam int RW = SUM_W + 1;
	localparam int QB = VAL_W + 1;

	logic [NW-1:0] n_full;
	logic [NW-1:0] n_hi;

	logic [RW-1:0]    rem_s [0:QB];
	logic [SUM_W-1:0] den_s [0:QB];
	logic [VAL_W:0]   nlo_s [0:QB];
	logic [VAL_W:0]   quo_s [0:QB];
	logic             ovf_s [0:QB];

	assign n_full = {num, FRAC_W'(0)};
	assign n_hi   = n_full >> QB;

	// quotient at or above 2^(VAL_W+1) is flagged up front, then VAL_W+1 bits remain
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= n_hi >= NW'(den);
			rem_s[0] <= RW'(n_hi);
			den_s[0] <= den;
			nlo_s[0] <= n_full[VAL_W:0];
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW-1:0] t;
		logic          ge;
		assign t  = {rem_s[k][RW-2:0], nlo_s[k][VAL_W]};
		assign ge = t >= RW'(den_s[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? t - RW'(den_s[k]) : t;
				den_s[k+1] <= den_s[k];
				nlo_s[k+1] <= {nlo_s[k][VAL_W-1:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][VAL_W-1:0], ge};
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];
endmodule

>>> test/projective_point_transform_2d_tb.sv
module projective_point_transform_2d_tb;
	import ppt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 38;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ppt_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ppt_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	projective_point_transform_2d dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// matrix copy, m[8] is the bottom-right entry
	logic signed [31:0] mat [9];
	logic [30:0] eps;
	ppt_out_t expected_points [$];
	int mismatches = 0;
	int points_sent = 0;
	int points_checked = 0;
	int small_w_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	int idle_cycles = 0;

	function automatic logic signed [63:0] floor_frac(input logic signed [63:0] v);
		return v >>> 16;
	endfunction

	function automatic logic signed [63:0] dot_row(input int r, input logic signed [31:0] x,
			input logic signed [31:0] y);
		logic signed [63:0] p0, p1, q0, q1;
		p0 = mat[3*r] * x;
		p1 = mat[3*r+1] * y;
		q0 = floor_frac(p0);
		q1 = floor_frac(p1);
		return q0 + q1 + 64'(mat[3*r+2]) + (((p0 - (q0 <<< 16)) + (p1 - (q1 <<< 16))) >>> 16);
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [31:0] fixed_divide(input logic signed [63:0] num,
			input logic signed [63:0] den);
		logic neg;
		logic [127:0] n, q;
		logic [127:0] lim;
		neg = (num < 0) != (den < 0);
		n = 128'(mag64(num)) << 16;
		q = n / 128'(mag64(den));
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (q > lim) q = lim;
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic ppt_out_t transform_point(input ppt_in_t p);
		logic signed [63:0] xp, yp, w;
		ppt_out_t r;
		xp = dot_row(0, p.x_in, p.y_in);
		yp = dot_row(1, p.x_in, p.y_in);
		w = dot_row(2, p.x_in, p.y_in);
		if (mag64(w) > 64'(eps)) begin
			r.x_out = fixed_divide(xp, w);
			r.y_out = fixed_divide(yp, w);
			r.w_small = 1'b0;
		end else begin
			r.x_out = clamp32(xp);
			r.y_out = clamp32(yp);
			r.w_small = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("mismatch %s: got %h expected %h (point %0d)", what, got, want, points_checked);
	endtask

	task automatic write_reg(input ppt_reg_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_M0_M1: begin mat[0] = value[63:32]; mat[1] = value[31:0]; end
			REG_M2_M3: begin mat[2] = value[63:32]; mat[3] = value[31:0]; end
			REG_M4_M5: begin mat[4] = value[63:32]; mat[5] = value[31:0]; end
			REG_M6_M7: begin mat[6] = value[63:32]; mat[7] = value[31:0]; end
			REG_M8: mat[8] = value[31:0];
			REG_EPS: eps = value[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_matrix(input logic signed [31:0] m [9], input logic [30:0] e);
		write_reg(REG_M0_M1, {m[0], m[1]});
		write_reg(REG_M2_M3, {m[2], m[3]});
		write_reg(REG_M4_M5, {m[4], m[5]});
		write_reg(REG_M6_M7, {m[6], m[7]});
		write_reg(REG_M8, {32'h0, m[8]});
		write_reg(REG_EPS, {33'h0, e});
	endtask

	// sender holds valid across back-to-back words
	task automatic send_point(input logic [31:0] x, input logic [31:0] y);
		ppt_in_t p;
		p.x_in = x;
		p.y_in = y;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		expected_points.push_back(transform_point(p));
		points_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (expected_points.size() == 0);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [31:0] random_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 * 1310720)) - 1310720);
			2: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
			default: return {$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom)};
		endcase
	endfunction

	function automatic logic [31:0] random_coef();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 262144)) - 131072);
			2: return {{14{1'($urandom_range(1))}}, 18'($urandom)};
			default: return 32'($signed($urandom_range(0, 2048)) - 1024);
		endcase
	endfunction

	task automatic random_matrix(input bit perspective);
		logic signed [31:0] m [9];
		for (int i = 0; i < 9; i++) m[i] = random_coef();
		if (!perspective) begin
			m[6] = $urandom_range(3) == 0 ? random_coef() : 32'(($urandom_range(63)) - 32);
			m[7] = $urandom_range(3) == 0 ? random_coef() : 32'(($urandom_range(63)) - 32);
			m[8] = $urandom_range(1) ? COEF_ONE : 32'($signed($urandom_range(0, 1 << 20)));
		end
		write_matrix(m, $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(4096)));
	endtask

	task automatic test_directed();
		logic signed [31:0] m [9];
		logic [31:0] edges [8] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
			32'h8000_0000, COEF_ONE, 32'hffff_0000, 32'h0003_8000};
		// identity from reset
		for (int i = 0; i < 8; i++) send_point(edges[i], edges[7 - i]);
		drain();
		// w zero everywhere with extreme epsilon: undivided path
		m = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, COEF_ZERO, COEF_ZERO, COEF_ZERO};
		write_matrix(m, 31'h7fff_ffff);
		for (int i = 0; i < 6; i++) send_point(edges[i + 2], edges[i]);
		drain();
		// tiny w: quotient saturates both ways
		m = '{COEF_ONE, 32'h0, 32'h0, 32'h0, 32'hffff_0000, 32'h0, 32'h0, 32'h0, 32'h2};
		write_matrix(m, 31'h0);
		send_point(32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'h8000_0000, 32'h4000_0000);
		send_point(32'h1, 32'hffff_ffff);
		drain();
		m[8] = 32'hffff_fffe;
		write_reg(REG_M8, {32'h0, m[8]});
		send_point(32'h0001_0000, 32'h0002_0000);
		drain();
		// w just at and above epsilon
		m[8] = 32'h5;
		write_reg(REG_M8, {32'h0, m[8]});
		write_reg(REG_EPS, 64'd5);
		send_point(32'h0001_0000, 32'h0);
		drain();
		m[8] = 32'h6;
		write_reg(REG_M8, {32'h0, m[8]});
		send_point(32'h0001_0000, 32'h0);
		drain();
		m[8] = 32'hffff_fffa;
		write_reg(REG_M8, {32'h0, m[8]});
		send_point(32'hffff_0000, 32'h7fff_ffff);
		drain();
	endtask

	task automatic test_random(input int rounds, input int per_round);
		for (int r = 0; r < rounds; r++) begin
			random_matrix($urandom_range(4) == 0);
			for (int i = 0; i < per_round; i++) send_point(random_coord(), random_coord());
			drain();
		end
	endtask

	task automatic test_idling();
		send_idle_pct = 68;
		test_random(2, 80);
		send_idle_pct = 0;
		recv_stall_pct = 68;
		test_random(2, 80);
		send_idle_pct = 29;
		recv_stall_pct = 29;
		test_random(2, 80);
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int i = 0; i < 120; i++) send_point(random_coord(), random_coord());
		wait (!hold_off);
		drain();
		// sender waits for all words back before each point
		for (int i = 0; i < 10; i++) begin
			send_point(random_coord(), random_coord());
			in_valid <= 1'b0;
			wait (expected_points.size() == 0);
			@(negedge clk);
		end
		drain();
	endtask

	// receiver: long hold-off on request, else random stalls
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		ppt_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					report_mismatch("unexpected word", out_data.x_out, 32'h0);
				end else begin
					want = expected_points.pop_front();
					if (out_data.x_out !== want.x_out)
						report_mismatch("x_out", out_data.x_out, want.x_out);
					if (out_data.y_out !== want.y_out)
						report_mismatch("y_out", out_data.y_out, want.y_out);
					if (out_data.w_small !== want.w_small)
						report_mismatch("w_small", 32'(out_data.w_small), 32'(want.w_small));
					if (want.w_small) small_w_seen++;
				end
				points_checked++;
			end
		end
	end

	// watchdog on cycles without any accepted word
	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_valid)
				idle_cycles = 0;
			else if (++idle_cycles >= STALL_LIMIT) begin
				$display("timeout with %0d words outstanding", expected_points.size());
				$display("projective_point_transform_2d verification failed");
				$finish;
			end
		end
	end

	initial begin
		mat = '{COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
			COEF_ZERO, COEF_ZERO, COEF_ONE};
		eps = EPS_RESET;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(10, 60);
		test_idling();
		test_backpressure();
		test_random(3, 80);
		$display("%0d points checked over many matrices, %0d on the undivided path,",
			points_checked, small_w_seen);
		$display("with idle, stall and full-pipeline backpressure phases");
		if (mismatches == 0 && expected_points.size() == 0)
			$display("projective_point_transform_2d verification clean");
		else
			$display("projective_point_transform_2d verification failed");
		$finish;
	end

endmodule

>>> files.f
src/ppt_pkg.sv
src/ppt_dot3.sv
src/ppt_div.sv
src/projective_point_transform_2d.sv
test/projective_point_transform_2d_tb.sv
